>>> src/ethtcp_pkg.sv
// ----------------------------------------------------------------------------
// ethtcp_pkg
// Shared types and constants of the Ethernet/IPv4/TCP payload extractor.
// ----------------------------------------------------------------------------
package ethtcp_pkg;

    // Default longest frame position tracked before the byte counter saturates.
    localparam int ETHTCP_MAX_FRAME_BYTES = 2048;

    // Header layout.
    localparam int ETH_HDR_LEN   = 14;
    localparam int ETH_TYPE_HI_POS = 12;
    localparam int ETH_TYPE_LO_POS = 13;
    localparam int IP_PROTO_OFS  = 9;
    localparam int TCP_DOFF_OFS  = 12;

    localparam logic [7:0] ETHERTYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETHERTYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP      = 8'h06;
    localparam logic [3:0] IHL_MIN           = 4'd5;
    localparam logic [3:0] DOFF_MIN          = 4'd4;

    localparam int PAYLOAD_LEN_W = 11;
    localparam logic [PAYLOAD_LEN_W-1:0] PAYLOAD_LEN_MAX = '1;

    // Result buffer geometry.
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;
    localparam int OBUF_CW    = 3;

    // Packed width of the result tdata (34 field bits, padded to 5 bytes).
    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_NOT_IPV4  = 3'd1,
        VERDICT_NOT_TCP   = 3'd2,
        VERDICT_TRUNCATED = 3'd3,
        VERDICT_MALFORMED = 3'd4
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t                item_kind;
        logic [7:0]                payload_byte;
        verdict_t                  verdict;
        logic [5:0]                ip_header_bytes;
        logic [5:0]                tcp_header_bytes;
        logic [PAYLOAD_LEN_W-1:0]  payload_total;
        logic                      run_end;
    } item_t;

    // Push request from the parser into the result buffer.
    typedef struct packed {
        logic  push_a;
        item_t item_a;
        logic  push_b;
        item_t item_b;
    } push_t;

endpackage

>>> src/eth_ipv4_tcp_payload_extractor.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_payload_extractor
// Parses a captured Ethernet frame byte by byte, checks for IPv4/TCP, forwards
// the TCP payload and closes each frame with a summary beat.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser     | tlast
//  s_      | in  | data_byte[7:0]                | -         | frame_last
//  m_      | out | payload_byte, verdict, ip_hdr,| item_kind | run_end
//          |     | tcp_hdr, payload_total        |           |
//
//  One input beat per cycle while s_tready is high, parsed in the same cycle
//  it is taken; its results (none, one payload beat, one summary beat, or
//  payload then summary) are written to the four-entry queue on acceptance.
//  s_tready is high while the queue has room for two results, so a frame
//  streams at one beat per cycle when the sink keeps up; it is a register
//  decode with no path from m_tready.
//  aresetn (synchronous, active low) clears the parser to its start-of-frame
//  state and empties the queue.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_payload_extractor
    import ethtcp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = ETHTCP_MAX_FRAME_BYTES
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // frame_last
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] payload_byte, [10:8] verdict, [16:11] ip_header_bytes,
    // [22:17] tcp_header_bytes, [33:23] payload_total, [39:34] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,   // item_kind
    output logic                 m_tlast    // run_end
);

    // Byte position counts up to MAX_FRAME_BYTES and holds there.
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    // Compare width: header end can reach 14 + 60 + 60.
    localparam int CW = (PW > 8) ? PW : 8;

    logic [PW-1:0]            pos_reg,     pos_next;
    logic [7:0]               type_hi_reg, type_hi_next;
    logic [5:0]               ip_len_reg,  ip_len_next;
    logic [5:0]               tcp_len_reg, tcp_len_next;
    verdict_t                 verdict_reg, verdict_next;
    logic [PAYLOAD_LEN_W-1:0] pay_cnt_reg, pay_cnt_next;

    logic       accept;
    logic       below_max;
    logic [CW-1:0] pos_ext, doff_pos, hdr_end_pos;
    logic [7:0] d;
    push_t      push;
    item_t      pay_item, sum_item;
    logic       pay_valid;
    item_t      out_item;

    assign accept = s_tvalid && s_tready;
    assign d      = s_tdata;

    assign below_max   = (pos_reg < PW'(MAX_FRAME_BYTES));
    assign pos_ext     = CW'(pos_reg);
    assign doff_pos    = CW'(ETH_HDR_LEN) + CW'(ip_len_reg) + CW'(TCP_DOFF_OFS);
    assign hdr_end_pos = CW'(ETH_HDR_LEN) + CW'(ip_len_reg) + CW'(tcp_len_reg)
                         - CW'(1);

    // Parse one byte: header capture, verdict update, payload forward.
    always_comb begin
        pos_next     = pos_reg;
        type_hi_next = type_hi_reg;
        ip_len_next  = ip_len_reg;
        tcp_len_next = tcp_len_reg;
        verdict_next = verdict_reg;
        pay_cnt_next = pay_cnt_reg;
        pay_valid    = 1'b0;

        if (verdict_reg == VERDICT_OK) begin
            // Headers done: forward and count, saturating.
            pay_valid = 1'b1;
            if (pay_cnt_reg != PAYLOAD_LEN_MAX) begin
                pay_cnt_next = pay_cnt_reg + PAYLOAD_LEN_W'(1);
            end
        end else if (verdict_reg == VERDICT_TRUNCATED && below_max) begin
            if (pos_ext == CW'(ETH_TYPE_HI_POS)) begin
                type_hi_next = d;
            end else if (pos_ext == CW'(ETH_TYPE_LO_POS)) begin
                if (type_hi_reg != ETHERTYPE_IPV4_HI || d != ETHERTYPE_IPV4_LO) begin
                    verdict_next = VERDICT_NOT_IPV4;
                end
            end else if (pos_ext == CW'(ETH_HDR_LEN)) begin
                ip_len_next = {d[3:0], 2'b00};
                if (d[3:0] < IHL_MIN) begin
                    verdict_next = VERDICT_MALFORMED;
                end
            end else if (pos_ext == CW'(ETH_HDR_LEN + IP_PROTO_OFS)) begin
                if (d != IP_PROTO_TCP) begin
                    verdict_next = VERDICT_NOT_TCP;
                end
            end else if (pos_ext == doff_pos) begin
                tcp_len_next = {d[7:4], 2'b00};
                if (d[7:4] < DOFF_MIN) begin
                    verdict_next = VERDICT_MALFORMED;
                end
            end else if (tcp_len_reg != '0 && pos_ext == hdr_end_pos) begin
                // Last TCP header byte: payload starts with the next beat.
                verdict_next = VERDICT_OK;
            end
        end

        if (below_max) begin
            pos_next = pos_reg + PW'(1);
        end

        // Summary reports the state after this byte, then start a new frame.
        sum_item.item_kind        = KIND_SUMMARY;
        sum_item.payload_byte     = '0;
        sum_item.verdict          = verdict_next;
        sum_item.ip_header_bytes  = ip_len_next;
        sum_item.tcp_header_bytes = tcp_len_next;
        sum_item.payload_total    = pay_cnt_next;
        sum_item.run_end          = 1'b1;

        if (s_tlast) begin
            pos_next     = '0;
            type_hi_next = '0;
            ip_len_next  = '0;
            tcp_len_next = '0;
            verdict_next = VERDICT_TRUNCATED;
            pay_cnt_next = '0;
        end
    end

    always_comb begin
        pay_item.item_kind        = KIND_PAYLOAD;
        pay_item.payload_byte     = d;
        pay_item.verdict          = VERDICT_OK;
        pay_item.ip_header_bytes  = '0;
        pay_item.tcp_header_bytes = '0;
        pay_item.payload_total    = '0;
        pay_item.run_end          = 1'b0;

        // Payload first, summary second; a lone summary takes the first slot.
        push.push_a = accept && (pay_valid || s_tlast);
        push.item_a = pay_valid ? pay_item : sum_item;
        push.push_b = accept && pay_valid && s_tlast;
        push.item_b = sum_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            type_hi_reg <= '0;
            ip_len_reg  <= '0;
            tcp_len_reg <= '0;
            verdict_reg <= VERDICT_TRUNCATED;
            pay_cnt_reg <= '0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            type_hi_reg <= type_hi_next;
            ip_len_reg  <= ip_len_next;
            tcp_len_reg <= tcp_len_next;
            verdict_reg <= verdict_next;
            pay_cnt_reg <= pay_cnt_next;
        end
    end

    ethtcp_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .out_ready (m_tready)
    );

    assign m_tdata = {6'b0, out_item.payload_total, out_item.tcp_header_bytes,
                      out_item.ip_header_bytes, out_item.verdict,
                      out_item.payload_byte};
    assign m_tuser = out_item.item_kind;
    assign m_tlast = out_item.run_end;

endmodule

>>> src/ethtcp_obuf.sv
// ----------------------------------------------------------------------------
// ethtcp_obuf
// Small result queue that takes up to two items per cycle and hands out one.
// ----------------------------------------------------------------------------
module ethtcp_obuf
    import ethtcp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    output item_t out_item,
    input  logic  out_ready
);

    item_t              mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0] head_reg, head_next;
    logic [OBUF_AW-1:0] tail_reg, tail_next;
    logic [OBUF_CW-1:0] count_reg, count_next;
    logic               pop;
    logic [OBUF_CW-1:0] n_push;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem[head_reg];
    assign pop       = out_valid && out_ready;
    // Room for a full pair keeps the input side free of any path from out_ready.
    assign room      = (count_reg <= OBUF_CW'(OBUF_DEPTH - 2));
    assign n_push    = OBUF_CW'(push.push_a) + OBUF_CW'(push.push_b);

    always_comb begin
        head_next  = head_reg + OBUF_AW'(pop);
        tail_next  = tail_reg + n_push[OBUF_AW-1:0];
        count_next = count_reg + n_push - OBUF_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            mem[tail_reg] <= push.item_a;
        end
        if (push.push_b) begin
            mem[tail_reg + OBUF_AW'(1)] <= push.item_b;
        end
    end

endmodule

>>> src/ethtcp_checker.sv
// ----------------------------------------------------------------------------
// ethtcp_checker
// Port-level checks for the payload extractor, bound to the top level.
// ----------------------------------------------------------------------------
module ethtcp_checker
    import ethtcp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A stalled result beat holds.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only while results are waiting.
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A frame end always yields a summary beat.
    a_last_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after frame end");

    // Summary verdict code is in range.
    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[10:8] <= 3'd4)
        else $error("verdict out of range");

endmodule

bind eth_ipv4_tcp_payload_extractor ethtcp_checker u_ethtcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/eth_ipv4_tcp_payload_checker.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_payload_checker
// Watches both streams of the payload extractor, predicts the payload and
// summary beats of every frame byte taken in, and compares them in order.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_payload_checker
    import ethtcp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = ETHTCP_MAX_FRAME_BYTES
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // frame_last
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] payload_byte, [10:8] verdict, [16:11] ip_header_bytes,
    // [22:17] tcp_header_bytes, [33:23] payload_total, [39:34] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,   // item_kind
    input  logic                 m_tlast,   // run_end
    output int                   mismatch_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    int                       frame_pos;
    logic [7:0]               ethertype_hi;
    logic [5:0]               ip_hdr_len;
    logic [5:0]               tcp_hdr_len;
    verdict_t                 frame_state;
    logic [PAYLOAD_LEN_W-1:0] fwd_count;
    item_t                    awaited_items[$];

    task automatic clear_frame();
        frame_pos    = 0;
        ethertype_hi = '0;
        ip_hdr_len   = '0;
        tcp_hdr_len  = '0;
        frame_state  = VERDICT_TRUNCATED;
        fwd_count    = '0;
    endtask

    // Advance the parser by one frame byte and queue the beats it causes.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        item_t it;
        if (frame_state == VERDICT_OK) begin
            it = '0;
            it.item_kind    = KIND_PAYLOAD;
            it.payload_byte = b;
            awaited_items.push_back(it);
            if (fwd_count != PAYLOAD_LEN_MAX) fwd_count++;
        end else if (frame_state == VERDICT_TRUNCATED && frame_pos < MAX_FRAME_BYTES) begin
            if (frame_pos == ETH_TYPE_HI_POS) begin
                ethertype_hi = b;
            end else if (frame_pos == ETH_TYPE_LO_POS) begin
                if (ethertype_hi != ETHERTYPE_IPV4_HI || b != ETHERTYPE_IPV4_LO)
                    frame_state = VERDICT_NOT_IPV4;
            end else if (frame_pos == ETH_HDR_LEN) begin
                ip_hdr_len = {b[3:0], 2'b00};
                if (b[3:0] < IHL_MIN) frame_state = VERDICT_MALFORMED;
            end else if (frame_pos == ETH_HDR_LEN + IP_PROTO_OFS) begin
                if (b != IP_PROTO_TCP) frame_state = VERDICT_NOT_TCP;
            end else if (frame_pos == ETH_HDR_LEN + int'(ip_hdr_len) + TCP_DOFF_OFS) begin
                tcp_hdr_len = {b[7:4], 2'b00};
                if (b[7:4] < DOFF_MIN) frame_state = VERDICT_MALFORMED;
            end else if (tcp_hdr_len != 0 &&
                         frame_pos == ETH_HDR_LEN + int'(ip_hdr_len) + int'(tcp_hdr_len) - 1) begin
                frame_state = VERDICT_OK;
            end
        end
        if (frame_pos < MAX_FRAME_BYTES) frame_pos++;
        if (last) begin
            it = '0;
            it.item_kind        = KIND_SUMMARY;
            it.verdict          = frame_state;
            it.ip_header_bytes  = ip_hdr_len;
            it.tcp_header_bytes = tcp_hdr_len;
            it.payload_total    = fwd_count;
            it.run_end          = 1'b1;
            awaited_items.push_back(it);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        item_t want;
        if (!aresetn) begin
            clear_frame();
            awaited_items.delete();
            mismatch_count = 0;
        end else begin
            // Compare before predicting: a beat leaving now never stems from
            // the byte taken at the same edge.
            if (m_tvalid && m_tready) begin
                if (awaited_items.size() == 0) begin
                    $error("unexpected result beat: tuser %0d tdata %h tlast %0d",
                           m_tuser, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = awaited_items.pop_front();
                    check_field("item_kind", 32'(want.item_kind), 32'(m_tuser));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(m_tdata[7:0]));
                    check_field("verdict", 32'(want.verdict), 32'(m_tdata[10:8]));
                    check_field("ip_header_bytes", 32'(want.ip_header_bytes),
                                32'(m_tdata[16:11]));
                    check_field("tcp_header_bytes", 32'(want.tcp_header_bytes),
                                32'(m_tdata[22:17]));
                    check_field("payload_total", 32'(want.payload_total),
                                32'(m_tdata[33:23]));
                    check_field("tdata_padding", 32'(0), 32'(m_tdata[M_TDATA_W-1:34]));
                    check_field("run_end", 32'(want.run_end), 32'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
        end
        pending_count = awaited_items.size();
    end

endmodule

>>> tb/tb_eth_ipv4_tcp_payload_extractor.sv
// ----------------------------------------------------------------------------
// tb_eth_ipv4_tcp_payload_extractor
// Feeds Ethernet frames byte by byte into the payload extractor: directed
// header corner cases first, then random well-formed and damaged frames, with
// random idling on both streams and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_tcp_payload_extractor;
    import ethtcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 700;      // bytes in the random part
    localparam int HOLD_CYCLES  = 300;      // long sink hold-off
    localparam int DRAIN_CYCLES = 16;       // quiet cycles after last result
    localparam int LIMIT_CYCLES = 400000;   // several times the slowest run
    localparam logic [15:0] ETHERTYPE_IPV4 = {ETHERTYPE_IPV4_HI, ETHERTYPE_IPV4_LO};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int         mismatch_count;
    int         pending_count;
    int         cycle_count = 0;
    int         sent_bytes;
    logic       idle_on;     // allow random gaps on both streams
    logic       press_go;    // ask the sink for its long hold-off
    logic [7:0] frame_bytes[$];

    always #2 aclk = ~aclk;

    eth_ipv4_tcp_payload_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    eth_ipv4_tcp_payload_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Hard stop: a hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sink: random stalls, plus one long hold-off counted here so the
    // result queue fills and the extractor drops s_tready.
    initial begin : sink
        bit pressed;
        pressed = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (press_go && !pressed) begin
                pressed = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Offer one byte and hold it until the extractor takes it. Called right
    // after a rising edge; returns right after the accepting edge.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Assemble a frame: MAC addresses, EtherType, IPv4 header, TCP header,
    // payload. A header too short to hold its own fields is padded to 20
    // bytes; the verdict is already malformed by then.
    task automatic build_frame(input int ihl, input int doff, input int plen,
                               input logic [15:0] etype, input logic [7:0] proto);
        int ip_bytes;
        int tcp_bytes;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        ip_bytes  = (ihl < 5) ? 20 : ihl * 4;
        tcp_bytes = (doff < 4) ? 20 : doff * 4;
        for (int i = 0; i < ip_bytes; i++) begin
            if (i == 0)                 frame_bytes.push_back({4'($urandom), 4'(ihl)});
            else if (i == IP_PROTO_OFS) frame_bytes.push_back(proto);
            else                        frame_bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < tcp_bytes; i++) begin
            if (i == TCP_DOFF_OFS) frame_bytes.push_back({4'(doff), 4'($urandom)});
            else                   frame_bytes.push_back(8'($urandom));
        end
        repeat (plen) frame_bytes.push_back(8'($urandom));
    endtask

    // Send the frame, cut to its first keep bytes when keep is nonzero.
    task automatic send_frame(input int keep);
        while (keep > 0 && frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        sent_bytes += frame_bytes.size();
    endtask

    initial begin : stimulus
        int sel;
        int ihl;
        int doff;
        int plen;
        logic [15:0] etype;
        logic [7:0]  proto;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        idle_on  <= 1'b1;
        press_go <= 1'b0;
        sent_bytes = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: frames that end at once, inside the MAC header, and
        // one byte short of the TCP header end all stay truncated.
        frame_bytes = '{8'h00};
        send_frame(0);
        frame_bytes = '{8'hFF};
        send_frame(0);
        build_frame(5, 5, 0, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(13);
        build_frame(6, 5, 0, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(ETH_HDR_LEN + 24 + 20 - 1);
        // Wrong EtherType, high and low byte; the rest is a valid TCP frame
        // so the first failure has to win.
        build_frame(5, 5, 4, 16'h86DD, IP_PROTO_TCP);
        send_frame(0);
        build_frame(5, 5, 4, 16'h0801, IP_PROTO_TCP);
        send_frame(0);
        build_frame(5, 5, 4, 16'h0000, IP_PROTO_TCP);
        send_frame(0);
        // Small IHL: malformed, protocol byte never looked at; then a non-TCP protocol.
        build_frame(0, 5, 4, ETHERTYPE_IPV4, 8'h11);
        send_frame(0);
        build_frame(4, 5, 4, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        build_frame(5, 5, 4, ETHERTYPE_IPV4, 8'h11);
        send_frame(0);
        // Small data offset.
        build_frame(5, 0, 4, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        build_frame(5, 3, 4, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        // Headers only, largest headers, smallest data offset.
        build_frame(5, 5, 0, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        build_frame(15, 15, 6, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        build_frame(5, 4, 1, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);
        // Longer payload run in one frame.
        build_frame(5, 5, 200, ETHERTYPE_IPV4, IP_PROTO_TCP);
        send_frame(0);

        // Random: mostly valid TCP frames with random content, the rest
        // damaged headers, cut frames and noise.
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            if (sent_bytes > RANDOM_BYTES * 17 / 20)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 5) != 0);
            if (sent_bytes > RANDOM_BYTES * 2 / 5) press_go <= 1'b1;

            sel   = $urandom_range(0, 99);
            ihl   = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
            doff  = $urandom_range(0, 1) ? 5 : $urandom_range(4, 15);
            plen  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80)
                                                : $urandom_range(0, 16);
            etype = ETHERTYPE_IPV4;
            proto = IP_PROTO_TCP;
            if (sel < 62) begin
                build_frame(ihl, doff, plen, etype, proto);
                send_frame(0);
            end else if (sel < 72) begin
                build_frame(ihl, doff, plen, etype, proto);
                send_frame($urandom_range(1, ETH_HDR_LEN + ihl * 4 + doff * 4 - 1));
            end else if (sel < 77) begin
                if ($urandom_range(0, 1)) etype = 16'($urandom);
                if (etype == ETHERTYPE_IPV4) etype ^= 16'(1 << $urandom_range(0, 15));
                build_frame(ihl, doff, plen, etype, proto);
                send_frame(0);
            end else if (sel < 82) begin
                proto = 8'($urandom);
                if (proto == IP_PROTO_TCP) proto ^= 8'(1 << $urandom_range(0, 7));
                build_frame(ihl, doff, plen, etype, proto);
                send_frame(0);
            end else if (sel < 86) begin
                build_frame($urandom_range(0, 4), doff, plen, etype, proto);
                send_frame(0);
            end else if (sel < 90) begin
                build_frame(ihl, $urandom_range(0, 3), plen, etype, proto);
                send_frame(0);
            end else begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 60)) frame_bytes.push_back(8'($urandom));
                send_frame(0);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain: wait for every predicted beat, then watch for strays.
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (pending_count != 0) $error("%0d expected beats never arrived", pending_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
